// ----- hw/rtl/tsfj_pkg.sv -----
package tsfj_pkg;

    // Input transaction codes.
    localparam logic [2:0] MODE_BEGIN_OPEN    = 3'd0;
    localparam logic [2:0] MODE_SCAN_PAGE     = 3'd1;
    localparam logic [2:0] MODE_FINISH_OPEN   = 3'd2;
    localparam logic [2:0] MODE_COMMIT_REQ    = 3'd3;
    localparam logic [2:0] MODE_COMMIT_RESULT = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LOADED  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DAMAGED = 3'd3;
    localparam logic [2:0] ST_IO      = 3'd4;
    localparam logic [2:0] ST_BAD     = 3'd5;

    localparam int          MAX_PAGES_DEFAULT = 4096;
    localparam logic [12:0] PPS_RESET         = 13'd16;
    localparam logic [12:0] PAGE_LIMIT        = 13'h1fff;
    localparam logic [15:0] DAMAGED_LIMIT     = 16'hffff;

    typedef struct packed {
        logic [2:0]  mode;
        logic        scan_sector;
        logic [11:0] scan_page;
        logic        io_ok;
        logic        record_empty;
        logic        record_valid;
        logic [31:0] record_generation;
        logic        verify_ok;
        logic [31:0] verify_generation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        erase_request;
        logic        target_sector;
        logic [12:0] program_page_address;
        logic [31:0] commit_generation;
        logic        live_valid;
        logic        live_sector;
        logic [15:0] damaged_total;
    } out_item_t;

endpackage

// ----- hw/rtl/two_sector_flash_journal_policy.sv -----
// Page allocation policy for a journal kept in two flash sectors. Software
// opens the journal with a begin-open transaction, one scan transaction per
// page read back from flash and a finish-open transaction; it then writes
// with a commit request (which names the sector, the global page address, the
// generation to encode and whether the sector must be erased first) followed
// by a commit result carrying the erase and verify outcomes. Every input
// transaction yields exactly one result transaction. The block takes one
// transaction per clock as long as the result side does not stall: each one
// sits in an input register while a single pass of compare and update logic
// works on it, and its result is then held in an output register. The
// pages_per_sector register (reset 16) may only be written while no
// transaction is in flight; it is not checked until begin-open, which
// refuses values of zero or above MAX_PAGES.
module two_sector_flash_journal_policy #(
    parameter int MAX_PAGES = tsfj_pkg::MAX_PAGES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tsfj_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tsfj_pkg::out_item_t out_data,
    input  logic                pages_per_sector_we,
    input  logic [12:0]         pages_per_sector_wdata
);

    localparam logic [16:0] MAX_PAGES_W = 17'(MAX_PAGES);

    // Pipeline registers.
    logic                in_valid_reg;
    tsfj_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg;
    tsfj_pkg::out_item_t out_data_reg;
    logic                advance;

    // Configuration and journal state.
    logic [12:0] pages_per_sector_reg;
    logic [12:0] nfp0_reg, nfp0_next;
    logic [12:0] nfp1_reg, nfp1_next;
    logic [31:0] live_gen_reg, live_gen_next;
    logic        live_present_reg, live_present_next;
    logic        live_slot_reg, live_slot_next;
    logic        write_en_reg, write_en_next;
    logic [15:0] damaged_reg, damaged_next;
    logic        pend_sector_reg, pend_sector_next;
    logic        pend_erase_reg, pend_erase_next;
    logic        pend_active_reg, pend_active_next;

    tsfj_pkg::out_item_t result;

    // Helper values for the decode below.
    logic        pps_ok;
    logic        page_in_range;
    logic [31:0] gen_delta;
    logic        gen_newer;
    logic [31:0] gen_plus_one;
    logic        req_first;
    logic [12:0] req_first_nfp;
    logic        req_slot;
    logic [12:0] req_nfp;
    logic        req_full;
    logic        req_refused;
    logic [12:0] req_page;
    logic [12:0] req_base;
    logic [12:0] res_base;
    logic [12:0] res_nfp;
    logic        res_verified;

    // The input register moves on whenever the output register is free or
    // being emptied in the same cycle.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        pps_ok        = (pages_per_sector_reg != 13'd0)
                        && ({4'd0, pages_per_sector_reg} <= MAX_PAGES_W);
        page_in_range = {1'b0, in_data_reg.scan_page} < pages_per_sector_reg;

        // Serial-number comparison: newer when the forward distance is
        // nonzero and below half the generation space.
        gen_delta     = in_data_reg.record_generation - live_gen_reg;
        gen_newer     = (gen_delta != 32'd0) && !gen_delta[31];
        gen_plus_one  = live_gen_reg + 32'd1;

        // Commit request: prefer the live sector, fall over to the other one
        // when it is full, and erase when both are full.
        req_first     = live_present_reg ? live_slot_reg : 1'b0;
        req_first_nfp = req_first ? nfp1_reg : nfp0_reg;
        req_slot      = (req_first_nfp >= pages_per_sector_reg) ? !req_first : req_first;
        req_nfp       = req_slot ? nfp1_reg : nfp0_reg;
        req_full      = req_nfp >= pages_per_sector_reg;
        req_refused   = req_full && live_present_reg && (req_slot == live_slot_reg);
        req_page      = req_full ? 13'd0 : req_nfp;
        req_base      = req_slot ? pages_per_sector_reg : 13'd0;

        // Commit result: the page is consumed unless the erase failed.
        res_base      = pend_erase_reg ? 13'd0
                        : (pend_sector_reg ? nfp1_reg : nfp0_reg);
        res_nfp       = (res_base < tsfj_pkg::PAGE_LIMIT) ? res_base + 13'd1 : res_base;
        res_verified  = in_data_reg.verify_ok
                        && (in_data_reg.verify_generation == gen_plus_one);

        nfp0_next         = nfp0_reg;
        nfp1_next         = nfp1_reg;
        live_gen_next     = live_gen_reg;
        live_present_next = live_present_reg;
        live_slot_next    = live_slot_reg;
        write_en_next     = write_en_reg;
        damaged_next      = damaged_reg;
        pend_sector_next  = pend_sector_reg;
        pend_erase_next   = pend_erase_reg;
        pend_active_next  = pend_active_reg;

        result                      = '0;
        result.status               = tsfj_pkg::ST_BAD;

        unique case (in_data_reg.mode)
            tsfj_pkg::MODE_BEGIN_OPEN:
            begin
                if (pps_ok)
                begin
                    nfp0_next         = '0;
                    nfp1_next         = '0;
                    live_gen_next     = '0;
                    live_present_next = 1'b0;
                    live_slot_next    = 1'b0;
                    write_en_next     = 1'b0;
                    damaged_next      = '0;
                    pend_sector_next  = 1'b0;
                    pend_erase_next   = 1'b0;
                    pend_active_next  = 1'b0;
                    result.status     = tsfj_pkg::ST_OK;
                end
            end
            tsfj_pkg::MODE_SCAN_PAGE:
            begin
                if (!in_data_reg.io_ok)
                begin
                    result.status = tsfj_pkg::ST_IO;
                end
                else if (page_in_range)
                begin
                    result.status = tsfj_pkg::ST_OK;
                    if (!in_data_reg.record_empty)
                    begin
                        if (in_data_reg.scan_sector)
                            nfp1_next = {1'b0, in_data_reg.scan_page} + 13'd1;
                        else
                            nfp0_next = {1'b0, in_data_reg.scan_page} + 13'd1;
                        if (!in_data_reg.record_valid)
                        begin
                            if (damaged_reg != tsfj_pkg::DAMAGED_LIMIT)
                                damaged_next = damaged_reg + 16'd1;
                        end
                        else if (!live_present_reg || gen_newer)
                        begin
                            live_gen_next     = in_data_reg.record_generation;
                            live_present_next = 1'b1;
                            live_slot_next    = in_data_reg.scan_sector;
                        end
                    end
                end
            end
            tsfj_pkg::MODE_FINISH_OPEN:
            begin
                if (!live_present_reg && (damaged_reg != 16'd0))
                begin
                    result.status = tsfj_pkg::ST_DAMAGED;
                end
                else
                begin
                    write_en_next = 1'b1;
                    result.status = live_present_reg ? tsfj_pkg::ST_LOADED
                                                     : tsfj_pkg::ST_EMPTY;
                end
            end
            tsfj_pkg::MODE_COMMIT_REQ:
            begin
                if (write_en_reg && !req_refused)
                begin
                    result.status               = tsfj_pkg::ST_OK;
                    result.erase_request        = req_full;
                    result.target_sector        = req_slot;
                    result.program_page_address = req_base + req_page;
                    result.commit_generation    = gen_plus_one;
                    pend_sector_next            = req_slot;
                    pend_erase_next             = req_full;
                    pend_active_next            = 1'b1;
                end
            end
            tsfj_pkg::MODE_COMMIT_RESULT:
            begin
                if (pend_active_reg)
                begin
                    pend_active_next = 1'b0;
                    pend_erase_next  = 1'b0;
                    if (pend_erase_reg && !in_data_reg.io_ok)
                    begin
                        result.status = tsfj_pkg::ST_IO;
                    end
                    else
                    begin
                        if (pend_sector_reg)
                            nfp1_next = res_nfp;
                        else
                            nfp0_next = res_nfp;
                        if (res_verified)
                        begin
                            live_gen_next     = gen_plus_one;
                            live_present_next = 1'b1;
                            live_slot_next    = pend_sector_reg;
                            result.status     = tsfj_pkg::ST_LOADED;
                        end
                        else
                        begin
                            result.status = tsfj_pkg::ST_IO;
                        end
                    end
                end
            end
            default:
            begin
                result.status = tsfj_pkg::ST_BAD;
            end
        endcase

        result.live_valid    = live_present_next;
        result.live_sector   = live_slot_next;
        result.damaged_total = damaged_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_data;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
            out_data_reg <= result;
    end

    // Journal state commits when a transaction leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nfp0_reg         <= '0;
            nfp1_reg         <= '0;
            live_gen_reg     <= '0;
            live_present_reg <= 1'b0;
            live_slot_reg    <= 1'b0;
            write_en_reg     <= 1'b0;
            damaged_reg      <= '0;
            pend_sector_reg  <= 1'b0;
            pend_erase_reg   <= 1'b0;
            pend_active_reg  <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            nfp0_reg         <= nfp0_next;
            nfp1_reg         <= nfp1_next;
            live_gen_reg     <= live_gen_next;
            live_present_reg <= live_present_next;
            live_slot_reg    <= live_slot_next;
            write_en_reg     <= write_en_next;
            damaged_reg      <= damaged_next;
            pend_sector_reg  <= pend_sector_next;
            pend_erase_reg   <= pend_erase_next;
            pend_active_reg  <= pend_active_next;
        end
    end

    // Sector size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pages_per_sector_reg <= tsfj_pkg::PPS_RESET;
        else if (pages_per_sector_we)
            pages_per_sector_reg <= pages_per_sector_wdata;
    end

endmodule

// ----- hw/rtl/tsfj_checker.sv -----
module tsfj_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input tsfj_pkg::out_item_t out_data
);

    // A result held back by the receiver stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    // Commit fields are only filled in by an accepted commit request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != tsfj_pkg::ST_OK)
        |-> !out_data.erase_request && (out_data.program_page_address == 13'd0)
            && (out_data.commit_generation == 32'd0) && !out_data.target_sector)
        else $error("commit fields set on a non-ok result");

    // A damaged open never has a live record.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == tsfj_pkg::ST_DAMAGED)
        |-> !out_data.live_valid && (out_data.damaged_total != 16'd0))
        else $error("damaged status with live record or zero damage count");

    // Loaded always reports a live record.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == tsfj_pkg::ST_LOADED) |-> out_data.live_valid)
        else $error("loaded status without live record");

endmodule

bind two_sector_flash_journal_policy tsfj_checker u_tsfj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- tb/two_sector_flash_journal_policy_tb.sv -----
`timescale 1ns / 100ps

// Self-checking testbench for the two-sector flash journal page allocator.
//
// A predictor in this module tracks the journal state (next free page of each
// sector, live generation and sector, damage count, pending commit) and works
// out the result of every input transaction at the clock edge where the block
// accepts it. The expected result goes into a queue. Each result transaction
// that the block delivers is compared against the oldest entry of that queue.
//
// The stimulus runs as a series of named tests: a short directed open and
// commit sequence, a walk through sector sizes including the refused ones, a
// run of damaged records that the damage counter must count, and finally
// random open and commit sessions under several sector sizes.
module two_sector_flash_journal_policy_tb;

    // Pipeline latency from an accepted transaction to its result.
    localparam int PIPE_LATENCY = 2;
    // Cycles with no transaction accepted and no result taken before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Minimum transactions sent in the random sessions, and per sector size setting.
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS = 160;
    // Damaged records scanned in one open by the damage count test.
    localparam int DAMAGE_RUN = 40;

    // How the readback of a committed page turns out.
    typedef enum int
    {
        VERIFY_GOOD,
        VERIFY_FAIL,
        VERIFY_WRONG_GEN
    } verify_outcome_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    tsfj_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    tsfj_pkg::out_item_t out_data;
    logic                pps_we;
    logic [12:0]         pps_wdata;

    two_sector_flash_journal_policy dut
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .in_data                (in_data),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .out_data               (out_data),
        .pages_per_sector_we    (pps_we),
        .pages_per_sector_wdata (pps_wdata)
    );

    // Journal state as the predictor sees it. The stimulus also reads it, so
    // that well-formed commits can carry the generation the block will want.
    logic [12:0] jr_pps;
    logic [12:0] jr_next_page [2];
    logic [31:0] jr_live_gen;
    logic        jr_live_present;
    logic        jr_live_slot;
    logic        jr_writable;
    logic [15:0] jr_damaged;
    logic        jr_pend_sector;
    logic        jr_pend_erase;
    logic        jr_pend_active;

    tsfj_pkg::out_item_t awaited_results [$];
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;
    int                  burst_left;
    int                  items_sent;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void journal_clear();
        jr_next_page[0] = '0;
        jr_next_page[1] = '0;
        jr_live_gen     = '0;
        jr_live_present = 1'b0;
        jr_live_slot    = 1'b0;
        jr_writable     = 1'b0;
        jr_damaged      = '0;
        jr_pend_sector  = 1'b0;
        jr_pend_erase   = 1'b0;
        jr_pend_active  = 1'b0;
    endfunction

    // Applies one accepted transaction to the journal state and returns the
    // result the block must produce for it.
    function automatic tsfj_pkg::out_item_t journal_predict(tsfj_pkg::in_item_t it);
        tsfj_pkg::out_item_t r;
        logic [31:0]         delta;
        logic [31:0]         gen;
        logic                slot;
        logic [12:0]         pg;
        logic                refused;
        r = '0;
        r.status = tsfj_pkg::ST_BAD;
        case (it.mode)
            tsfj_pkg::MODE_BEGIN_OPEN:
            begin
                // A sector size outside 1..MAX_PAGES is refused untouched.
                if (jr_pps >= 13'd1 && int'(jr_pps) <= tsfj_pkg::MAX_PAGES_DEFAULT)
                begin
                    journal_clear();
                    r.status = tsfj_pkg::ST_OK;
                end
            end
            tsfj_pkg::MODE_SCAN_PAGE:
            begin
                if (!it.io_ok)
                    r.status = tsfj_pkg::ST_IO;
                else if ({1'b0, it.scan_page} >= jr_pps)
                    r.status = tsfj_pkg::ST_BAD;
                else
                begin
                    r.status = tsfj_pkg::ST_OK;
                    if (!it.record_empty)
                    begin
                        // The last non-empty scan decides, whatever the order.
                        jr_next_page[it.scan_sector] = {1'b0, it.scan_page} + 13'd1;
                        if (!it.record_valid)
                        begin
                            if (jr_damaged != tsfj_pkg::DAMAGED_LIMIT)
                                jr_damaged = jr_damaged + 16'd1;
                        end
                        else
                        begin
                            // Serial-number comparison: newer means a nonzero
                            // forward distance of less than half the range.
                            delta = it.record_generation - jr_live_gen;
                            if (!jr_live_present || (delta != 0 && delta < 32'h8000_0000))
                            begin
                                jr_live_gen     = it.record_generation;
                                jr_live_present = 1'b1;
                                jr_live_slot    = it.scan_sector;
                            end
                        end
                    end
                end
            end
            tsfj_pkg::MODE_FINISH_OPEN:
            begin
                if (!jr_live_present && jr_damaged != 0)
                    r.status = tsfj_pkg::ST_DAMAGED;
                else
                begin
                    jr_writable = 1'b1;
                    r.status = jr_live_present ? tsfj_pkg::ST_LOADED : tsfj_pkg::ST_EMPTY;
                end
            end
            tsfj_pkg::MODE_COMMIT_REQ:
            begin
                if (jr_writable)
                begin
                    // Prefer the live sector, fall over to the other one when
                    // it is full, and erase when both are full.
                    slot = jr_live_present ? jr_live_slot : 1'b0;
                    if (jr_next_page[slot] >= jr_pps)
                        slot = ~slot;
                    pg = jr_next_page[slot];
                    refused = 1'b0;
                    if (pg >= jr_pps)
                    begin
                        refused = jr_live_present && (slot == jr_live_slot);
                        r.erase_request = 1'b1;
                        pg = '0;
                    end
                    if (refused)
                        r.erase_request = 1'b0;
                    else
                    begin
                        r.target_sector        = slot;
                        r.program_page_address = (slot ? jr_pps : 13'd0) + pg;
                        r.commit_generation    = jr_live_gen + 32'd1;
                        jr_pend_sector = slot;
                        jr_pend_erase  = r.erase_request;
                        jr_pend_active = 1'b1;
                        r.status = tsfj_pkg::ST_OK;
                    end
                end
            end
            tsfj_pkg::MODE_COMMIT_RESULT:
            begin
                if (jr_pend_active)
                begin
                    slot = jr_pend_sector;
                    jr_pend_active = 1'b0;
                    if (jr_pend_erase && !it.io_ok)
                        r.status = tsfj_pkg::ST_IO;
                    else
                    begin
                        // The page is used up even when the verify fails.
                        gen = jr_live_gen + 32'd1;
                        if (jr_pend_erase)
                            jr_next_page[slot] = '0;
                        if (jr_next_page[slot] != tsfj_pkg::PAGE_LIMIT)
                            jr_next_page[slot] = jr_next_page[slot] + 13'd1;
                        if (!it.verify_ok || it.verify_generation != gen)
                            r.status = tsfj_pkg::ST_IO;
                        else
                        begin
                            jr_live_gen     = gen;
                            jr_live_present = 1'b1;
                            jr_live_slot    = slot;
                            r.status = tsfj_pkg::ST_LOADED;
                        end
                    end
                    jr_pend_erase = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.live_valid    = jr_live_present;
        r.live_sector   = jr_live_slot;
        r.damaged_total = jr_damaged;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    // Fields are printed as status/erase/sector/address/generation/
    // live valid/live sector/damaged.
    function automatic string fields_text(tsfj_pkg::out_item_t v);
        return $sformatf("%0d/%0b/%0b/%0d/%h/%0b/%0b/%0d",
                         v.status, v.erase_request, v.target_sector,
                         v.program_page_address, v.commit_generation,
                         v.live_valid, v.live_sector, v.damaged_total);
    endfunction

    function automatic void log_mismatch(string what, tsfj_pkg::out_item_t want,
                                         tsfj_pkg::out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %s got %s", $realtime, what,
                     fields_text(want), fields_text(got));
    endfunction

    // Everything here samples at the rising edge, where the values driven at
    // the previous falling edge are stable.
    always @(posedge clk)
    begin : result_check
        tsfj_pkg::out_item_t want;
        logic                moved;
        moved = 1'b0;
        if (rst_n && in_valid && !in_stall)
        begin
            awaited_results.push_back(journal_predict(in_data));
            moved = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            moved = 1'b1;
            if (awaited_results.size() == 0)
                log_mismatch("result with nothing awaited", '0, out_data);
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.status !== want.status
                    || out_data.erase_request !== want.erase_request
                    || out_data.target_sector !== want.target_sector
                    || out_data.program_page_address !== want.program_page_address
                    || out_data.commit_generation !== want.commit_generation
                    || out_data.live_valid !== want.live_valid
                    || out_data.live_sector !== want.live_sector
                    || out_data.damaged_total !== want.damaged_total)
                    log_mismatch("result mismatch", want, out_data);
            end
        end
        // A run that stops moving is either hung or has lost results; both
        // end up here rather than waiting forever.
        if (moved || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side stalls on its own schedule: stretches with no stall,
    // light and heavy random stalling, and a regular periodic pattern.
    initial
    begin : result_stall
        int style;
        int span;
        int tick;
        out_stall = 1'b0;
        tick = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 200);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // A transaction with every field random; callers overwrite what matters.
    function automatic tsfj_pkg::in_item_t noise_item();
        logic [95:0]        raw;
        tsfj_pkg::in_item_t it;
        raw = {$urandom(), $urandom(), $urandom()};
        it = raw[$bits(tsfj_pkg::in_item_t)-1:0];
        return it;
    endfunction

    function automatic tsfj_pkg::in_item_t shaped_item(input logic [2:0] mode);
        tsfj_pkg::in_item_t it;
        it = noise_item();
        it.mode = mode;
        return it;
    endfunction

    // Sends one transaction and returns at the falling edge after it was
    // accepted. The sender works in bursts; between bursts valid drops for a
    // random number of cycles. Valid is left high on return so that a
    // following transaction goes out back to back; wait_idle lowers it.
    task automatic send_txn(input tsfj_pkg::in_item_t it);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_mode(input logic [2:0] mode);
        send_txn(shaped_item(mode));
    endtask

    task automatic scan_one(input logic sec, input int page, input logic empty,
                            input logic good, input logic [31:0] gen);
        tsfj_pkg::in_item_t it;
        it = shaped_item(tsfj_pkg::MODE_SCAN_PAGE);
        it.scan_sector       = sec;
        it.scan_page         = 12'(page);
        it.io_ok             = 1'b1;
        it.record_empty      = empty;
        it.record_valid      = good;
        it.record_generation = gen;
        send_txn(it);
    endtask

    // A commit request followed by its result. The verify generation is taken
    // from the predictor after the request, which is what a good readback
    // would carry.
    task automatic commit_cycle(input logic erase_ok, input verify_outcome_t outcome);
        tsfj_pkg::in_item_t it;
        send_mode(tsfj_pkg::MODE_COMMIT_REQ);
        it = shaped_item(tsfj_pkg::MODE_COMMIT_RESULT);
        it.io_ok             = erase_ok;
        it.verify_ok         = (outcome != VERIFY_FAIL);
        it.verify_generation = jr_live_gen + 32'd1;
        if (outcome == VERIFY_WRONG_GEN)
            it.verify_generation = it.verify_generation + 32'($urandom_range(1, 1000));
        send_txn(it);
    endtask

    // Lets every awaited result arrive, then leaves the pipeline time to
    // empty before anything touches the sector size register.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_pps(input logic [12:0] value);
        wait_idle();
        pps_we    <= 1'b1;
        pps_wdata <= value;
        @(posedge clk);
        jr_pps = value;
        @(negedge clk);
        pps_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size of 16 pages: commands before any open, the three ways an
    // open can end, scan failures, generation wrap and equal generations,
    // out-of-order scans, repeated requests and a bad readback.
    task automatic test_directed_open_commit();
        tsfj_pkg::in_item_t it;
        send_mode(tsfj_pkg::MODE_COMMIT_REQ);        // not writable yet
        send_mode(tsfj_pkg::MODE_COMMIT_RESULT);     // nothing pending
        send_mode(3'd5);                             // unused modes
        send_mode(3'd7);
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);       // empty journal
        it = shaped_item(tsfj_pkg::MODE_SCAN_PAGE);
        it.io_ok = 1'b0;
        send_txn(it);                                // flash read failed
        scan_one(1'b0, 16, 1'b0, 1'b1, 32'd5);       // one past the last page
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        scan_one(1'b1, 2, 1'b0, 1'b0, 32'd0);        // damaged record only
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        send_mode(tsfj_pkg::MODE_COMMIT_REQ);        // writing stays disabled
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        scan_one(1'b0, 0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        scan_one(1'b1, 0, 1'b0, 1'b1, 32'h0000_0000);   // newer across the wrap
        scan_one(1'b0, 15, 1'b1, 1'b1, 32'h1234_5678);  // empty page, no effect
        scan_one(1'b1, 1, 1'b0, 1'b1, 32'h8000_0000);   // exactly half: not newer
        scan_one(1'b0, 3, 1'b0, 1'b1, 32'h0000_0000);   // equal: not newer
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        send_mode(tsfj_pkg::MODE_COMMIT_REQ);        // replaced by the next request
        commit_cycle(1'b1, VERIFY_WRONG_GEN);
        commit_cycle(1'b1, VERIFY_GOOD);
        send_mode(tsfj_pkg::MODE_COMMIT_RESULT);     // nothing pending any more
    endtask

    // Sector sizes at and beyond the limits, the erase path with full
    // sectors, and a failed erase.
    task automatic test_sector_sizes();
        write_pps(13'd0);
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        scan_one(1'b0, 0, 1'b0, 1'b1, $urandom());
        commit_cycle(1'b1, VERIFY_GOOD);

        // Opens are refused above MAX_PAGES, but the old state lives on and
        // addresses wrap to 13 bits.
        write_pps(13'h1FFF);
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        scan_one(1'b1, 4095, 1'b0, 1'b1, $urandom());
        commit_cycle(1'b1, VERIFY_GOOD);
        write_pps(13'(tsfj_pkg::MAX_PAGES_DEFAULT + 1));
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);

        write_pps(13'(tsfj_pkg::MAX_PAGES_DEFAULT));
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        scan_one(1'b0, 4095, 1'b0, 1'b1, 32'h7FFF_FFFF);
        scan_one(1'b1, 4095, 1'b0, 1'b1, 32'h8000_0000);
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        commit_cycle(1'b0, VERIFY_GOOD);   // both full: erase fails
        commit_cycle(1'b1, VERIFY_GOOD);
        commit_cycle(1'b1, VERIFY_FAIL);

        // One page per sector forces an erase on every commit after the first two.
        write_pps(13'd1);
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        for (int k = 0; k < 8; k++)
            commit_cycle(k != 4, (k == 6) ? VERIFY_FAIL : VERIFY_GOOD);
    endtask

    // A run of damaged records that the damage count must follow, then an
    // open that ends damaged.
    task automatic test_damage_count();
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        repeat (DAMAGE_RUN)
            scan_one(1'($urandom_range(0, 1)), 0, 1'b0, 1'b0, $urandom());
        send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        send_mode(tsfj_pkg::MODE_COMMIT_REQ);
        send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
    endtask

    // Scans one sector filled up to the given page count. Short sectors are
    // scanned in full, forward or backward; long ones at random pages, with
    // the last written page at the end.
    task automatic scan_sector_run(input logic sec, input int fill,
                                   inout logic [31:0] gen);
        int page;
        bit backward;
        backward = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < ((fill <= 10) ? fill : 10); k++)
        begin
            if (fill <= 10)
                page = backward ? fill - 1 - k : k;
            else
                page = (k == 9) ? fill - 1 : $urandom_range(0, fill - 1);
            if ($urandom_range(0, 19) == 0)
                gen = gen - 32'h100;
            scan_one(sec, page, 1'b0, $urandom_range(0, 14) != 0, gen);
            gen = gen + 32'($urandom_range(0, 2));
        end
        if (fill < int'(jr_pps) && $urandom_range(0, 1) == 0)
            scan_one(sec, fill, 1'b1, 1'($urandom_range(0, 1)), $urandom());
    endtask

    // One open followed by a few commits. Mostly well formed, with some
    // skipped or doubled steps and random noise mixed in.
    task automatic run_session();
        logic [31:0]        gen;
        int                 fill;
        int                 pick;
        tsfj_pkg::in_item_t it;
        verify_outcome_t    outcome;
        if ($urandom_range(0, 9) != 0)
            send_mode(tsfj_pkg::MODE_BEGIN_OPEN);
        gen = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFF8 : $urandom();
        for (int s = 0; s < 2; s++)
        begin
            pick = $urandom_range(0, 3);
            fill = (pick == 0) ? 0 : (pick == 1) ? int'(jr_pps)
                                   : $urandom_range(0, int'(jr_pps));
            scan_sector_run(1'(s), fill, gen);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            it = shaped_item(tsfj_pkg::MODE_SCAN_PAGE);
            it.io_ok = 1'b0;
            send_txn(it);
        end
        else if (pick == 1 && int'(jr_pps) <= 4095)
            scan_one(1'($urandom_range(0, 1)), $urandom_range(int'(jr_pps), 4095),
                     1'b0, 1'b1, $urandom());
        if ($urandom_range(0, 9) != 0)
            send_mode(tsfj_pkg::MODE_FINISH_OPEN);
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 11) == 0)
                send_mode(tsfj_pkg::MODE_COMMIT_REQ);
            pick = $urandom_range(0, 9);
            outcome = (pick == 0) ? VERIFY_FAIL : (pick == 1) ? VERIFY_WRONG_GEN
                                                              : VERIFY_GOOD;
            if ($urandom_range(0, 19) == 0)
                send_mode(tsfj_pkg::MODE_COMMIT_REQ);
            else
                commit_cycle($urandom_range(0, 9) != 0, outcome);
            if ($urandom_range(0, 19) == 0)
                send_mode(tsfj_pkg::MODE_COMMIT_RESULT);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_txn(noise_item());
    endtask

    // Random sessions under a rotation of sector sizes, from one page up to
    // the full 4096.
    task automatic test_random_sessions();
        int          start;
        int          phase_start;
        int          phase;
        logic [12:0] sector_pages;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case (phase % 6)
                0: sector_pages = 13'd1;
                1: sector_pages = 13'd2;
                2: sector_pages = 13'($urandom_range(3, 24));
                3: sector_pages = tsfj_pkg::PPS_RESET;
                4: sector_pages = 13'(tsfj_pkg::MAX_PAGES_DEFAULT);
                default: sector_pages = 13'($urandom_range(1, tsfj_pkg::MAX_PAGES_DEFAULT));
            endcase
            write_pps(sector_pages);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_session();
            phase++;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        pps_we     = 1'b0;
        pps_wdata  = '0;
        burst_left = 0;
        items_sent = 0;
        jr_pps     = tsfj_pkg::PPS_RESET;
        journal_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_open_commit();
        test_sector_sizes();
        test_damage_count();
        test_random_sessions();
        wait_idle();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
